FILE: sv/lpht_pkg.sv
// Shared types and codes for the linear-probe hash table unit.
// Used by lpht_home, lpht_store and linear_probe_hash_table_unit.
`default_nettype none

package lpht_pkg;

  // Field widths of one beat.
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned INT_W  = 32;
  localparam int unsigned BITS_W = 64;
  localparam int unsigned SLOT_W = 5;

  // Operation codes.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // Slot states.
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;

  // Result status codes.
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_FULL      = 2'd2;

  // One stored entry: key and payload.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [INT_W-1:0]  vint;
    logic [BITS_W-1:0] vbits;
  } entry_t;

  // Access request from the probe controller to the slot store.
  typedef struct packed {
    logic       rd_en;
    logic       st_we;
    logic       ent_we;
    logic [1:0] st_wdata;
  } store_req_t;

endpackage

`default_nettype wire

FILE: sv/linear_probe_hash_table_unit.sv
// Top level of the linear-probe hash table: probe controller and result register.
// Depends on lpht_pkg, lpht_home and lpht_store.
//
// Usage:
//   The input stream carries one operation per beat: insert, find or delete.
//   The output stream returns exactly one result beat per input beat, in order.
//   After accepting a beat the unit forms the home slot (a reciprocal multiply,
//   then a multiply and subtract), then probes one slot per cycle out of the
//   slot store (one read port, registered read), ending on a hit, on an empty
//   slot, or after one full lap.
//   A walk probes from 1 to TABLE_SLOTS slots; an unused mode answers without
//   probing.
//   One operation is worked on at a time; in_tready rises again as soon as the
//   result sits in the output register, while it may still wait for out_tready.
//   If the receiver stalls, the output register holds its beat and a finished
//   next result waits inside, with in_tready low, until the register frees up.
//   After reset the slot state memory is cleared in a pass during which
//   in_tready stays low; afterwards the table is empty.
`default_nettype none

module linear_probe_hash_table_unit #(
  parameter int unsigned TABLE_SLOTS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[1:0], key[32:2], value_int[64:33], value_bits[128:65], zero pad above
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0], slot[6:2], found_int[38:7], found_bits[102:39], zero pad above
  output logic [103:0]      out_tdata
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOME,
    S_PROBE,
    S_DONE
  } state_t;

  state_t state_r;

  // Operation registers.
  logic [1:0]                     mode_r;
  logic [lpht_pkg::KEY_W-1:0]     key_r;
  logic [lpht_pkg::INT_W-1:0]     vint_r;
  logic [lpht_pkg::BITS_W-1:0]    vbits_r;

  // Probe registers.
  logic [AW-1:0] addr_r;
  logic [AW-1:0] pend_addr_r;
  logic [CW-1:0] issued_r;

  // Result registers.
  logic [1:0]                     res_status_r;
  logic [lpht_pkg::SLOT_W-1:0]    res_slot_r;
  logic [lpht_pkg::INT_W-1:0]     res_int_r;
  logic [lpht_pkg::BITS_W-1:0]    res_bits_r;

  logic         out_tvalid_r;
  logic [103:0] out_tdata_r;

  logic                 home_start;
  logic                 home_done;
  logic [AW-1:0]        home;
  lpht_pkg::store_req_t req;
  logic [AW-1:0]        rd_addr;
  lpht_pkg::entry_t     wr_entry;
  logic [1:0]           rd_status;
  lpht_pkg::entry_t     rd_entry;
  logic                 clearing;

  logic in_accept;
  logic mode_ok;
  logic is_insert;
  logic is_lookup;
  logic hit_ins;
  logic hit_fd;
  logic miss_fd;
  logic lap_end;
  logic out_free;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == AW'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  lpht_home #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .AW          (AW)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (in_tdata[32:2]),
    .done  (home_done),
    .home  (home)
  );

  lpht_store #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rd_addr   (rd_addr),
    .wr_addr   (pend_addr_r),
    .wr_entry  (wr_entry),
    .rd_status (rd_status),
    .rd_entry  (rd_entry),
    .clearing  (clearing)
  );

  // Input handshake.
  assign in_tready  = (state_r == S_IDLE) && !clearing;
  assign in_accept  = in_tvalid && in_tready;
  assign home_start = in_accept;

  // Decode the operation and the slot under evaluation.
  assign is_insert = (mode_r == lpht_pkg::MODE_INSERT);
  assign is_lookup = (mode_r == lpht_pkg::MODE_FIND) || (mode_r == lpht_pkg::MODE_DELETE);
  assign mode_ok   = is_insert || is_lookup;
  assign hit_ins   = is_insert && (rd_status != lpht_pkg::ST_USED);
  assign hit_fd    = is_lookup && (rd_status == lpht_pkg::ST_USED) && (rd_entry.key == key_r);
  assign miss_fd   = is_lookup && (rd_status == lpht_pkg::ST_EMPTY);
  assign lap_end   = (issued_r == CW'(TABLE_SLOTS));
  assign out_free  = !out_tvalid_r || out_tready;

  // Store accesses: one probe read per cycle, write back on an insert or delete hit.
  always_comb begin
    req.rd_en    = 1'b0;
    req.st_we    = 1'b0;
    req.ent_we   = 1'b0;
    req.st_wdata = hit_ins ? lpht_pkg::ST_USED : lpht_pkg::ST_DELETED;
    rd_addr      = addr_r;
    if (state_r == S_HOME) begin
      rd_addr   = home;
      req.rd_en = home_done && mode_ok;
    end else if (state_r == S_PROBE) begin
      req.st_we  = hit_ins || (hit_fd && (mode_r == lpht_pkg::MODE_DELETE));
      req.ent_we = hit_ins;
      req.rd_en  = !hit_ins && !hit_fd && !miss_fd && !lap_end;
    end
  end

  assign wr_entry.key   = key_r;
  assign wr_entry.vint  = vint_r;
  assign wr_entry.vbits = vbits_r;

  // Probe controller and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            mode_r  <= in_tdata[1:0];
            key_r   <= in_tdata[32:2];
            vint_r  <= in_tdata[64:33];
            vbits_r <= in_tdata[128:65];
            state_r <= S_HOME;
          end
        end
        S_HOME: begin
          if (home_done) begin
            if (mode_ok) begin
              pend_addr_r <= home;
              addr_r      <= next_slot(home);
              issued_r    <= CW'(1);
              state_r     <= S_PROBE;
            end else begin
              res_status_r <= lpht_pkg::RES_NOT_FOUND;
              res_slot_r   <= '0;
              res_int_r    <= '0;
              res_bits_r   <= '0;
              state_r      <= S_DONE;
            end
          end
        end
        S_PROBE: begin
          if (hit_ins) begin
            res_status_r <= lpht_pkg::RES_OK;
            res_slot_r   <= lpht_pkg::SLOT_W'(pend_addr_r);
            res_int_r    <= '0;
            res_bits_r   <= '0;
            state_r      <= S_DONE;
          end else if (hit_fd) begin
            res_status_r <= lpht_pkg::RES_OK;
            res_slot_r   <= lpht_pkg::SLOT_W'(pend_addr_r);
            res_int_r    <= rd_entry.vint;
            res_bits_r   <= rd_entry.vbits;
            state_r      <= S_DONE;
          end else if (miss_fd || lap_end) begin
            res_status_r <= is_insert ? lpht_pkg::RES_FULL : lpht_pkg::RES_NOT_FOUND;
            res_slot_r   <= '0;
            res_int_r    <= '0;
            res_bits_r   <= '0;
            state_r      <= S_DONE;
          end else begin
            pend_addr_r <= addr_r;
            addr_r      <= next_slot(addr_r);
            issued_r    <= issued_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, res_bits_r, res_int_r, res_slot_r, res_status_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // No beat is taken while the slot state memory is still being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input accepted during clearing pass");

  // The probe walk never goes past one full lap.
  a_lap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (issued_r <= CW'(TABLE_SLOTS)) && (issued_r != '0))
    else $error("probe count out of range");

  // The table is only written while a probe resolves.
  a_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (req.st_we || req.ent_we) |-> (state_r == S_PROBE) && !clearing)
    else $error("store write outside of probe");

  // The home slot arrives only while the controller waits for it.
  a_home_timing: assert property (@(posedge clk) disable iff (!rst_n)
    home_done |-> (state_r == S_HOME))
    else $error("home slot done in wrong state");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_tvalid_r && !out_tready |=> out_tvalid_r && (state_r == S_DONE))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

FILE: sv/lpht_home.sv
// Home slot unit: key modulo the table size by reciprocal multiplication.
// Depends on lpht_pkg for the key width.
`default_nettype none

module lpht_home #(
  parameter int unsigned TABLE_SLOTS = 32,
  parameter int unsigned AW          = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [lpht_pkg::KEY_W-1:0]   key,
  output logic                              done,
  output logic [AW-1:0]                     home
);

  // Scaled reciprocal of the table size; the quotient is exact for every key.
  localparam int unsigned     LW    = $clog2(TABLE_SLOTS);
  localparam int unsigned     SH    = lpht_pkg::KEY_W + LW;
  localparam int unsigned     RCW   = lpht_pkg::KEY_W + 1;
  localparam int unsigned     PW    = lpht_pkg::KEY_W + RCW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(TABLE_SLOTS) - 64'd1)
                                      / 64'(TABLE_SLOTS);

  logic [lpht_pkg::KEY_W-1:0] key_r;
  logic [PW-1:0]              prod_r;
  logic [lpht_pkg::KEY_W-1:0] quot;
  logic [lpht_pkg::KEY_W-1:0] rem;
  logic [AW-1:0]              home_r;
  logic                       busy_r;
  logic                       done_r;

  // Quotient from the scaled product, remainder by one constant multiply.
  always_comb begin
    quot = lpht_pkg::KEY_W'(prod_r >> SH);
    rem  = key_r - quot * lpht_pkg::KEY_W'(TABLE_SLOTS);
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        key_r  <= key;
        prod_r <= PW'(key) * PW'(RECIP);
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        home_r <= rem[AW-1:0];
      end
    end
  end

  assign done = done_r;
  assign home = home_r;

endmodule

`default_nettype wire

FILE: sv/lpht_store.sv
// Slot store: slot state memory and entry memory, registered read.
// Clears the state memory after reset. Depends on lpht_pkg.
`default_nettype none

module lpht_store #(
  parameter int unsigned TABLE_SLOTS = 32,
  parameter int unsigned AW          = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lpht_pkg::store_req_t req,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire lpht_pkg::entry_t     wr_entry,
  output logic [1:0]                rd_status,
  output lpht_pkg::entry_t          rd_entry,
  output logic                      clearing
);

  logic [1:0]        st_mem  [TABLE_SLOTS];
  lpht_pkg::entry_t  ent_mem [TABLE_SLOTS];

  logic [AW-1:0]     clr_cnt_r;
  logic              clearing_r;
  logic [1:0]        rd_status_r;
  lpht_pkg::entry_t  rd_entry_r;

  // Clearing pass: one slot per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(TABLE_SLOTS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // State memory write port, shared with the clearing pass.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      st_mem[clr_cnt_r] <= lpht_pkg::ST_EMPTY;
    end else if (req.st_we) begin
      st_mem[wr_addr] <= req.st_wdata;
    end
  end

  // Entry memory write port.
  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      ent_mem[wr_addr] <= wr_entry;
    end
  end

  // Registered read of both memories at one address.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_status_r <= st_mem[rd_addr];
      rd_entry_r  <= ent_mem[rd_addr];
    end
  end

  assign rd_status = rd_status_r;
  assign rd_entry  = rd_entry_r;
  assign clearing  = clearing_r;

endmodule

`default_nettype wire
